>>> rtl/ppc_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and constants for the point projection colorizer.
// No dependencies; ppc_axis, ppc_frame_mem and the top level refer to it by scoped name.
package ppc_pkg;

  localparam int FIX_W = 20;
  localparam int SIZE_W = 12;
  localparam int NUM_W = 56;
  localparam int DEN_W = 40;
  localparam int CH_W = 8;
  localparam int SUM_W = 11;
  localparam int NTAP = 5;
  localparam int CFG_AW = 5;

  localparam logic FUNC_PIXEL = 1'b0;

  localparam logic [FIX_W-1:0] RST_FOCAL_X = 20'd198215;
  localparam logic [FIX_W-1:0] RST_FOCAL_Y = 20'd198259;
  localparam logic [FIX_W-1:0] RST_CENTER_X = 20'd200688;
  localparam logic [FIX_W-1:0] RST_CENTER_Y = 20'd146979;
  localparam logic [SIZE_W-1:0] RST_COLS = 12'd1600;
  localparam logic [SIZE_W-1:0] RST_ROWS = 12'd1200;

  localparam logic [CH_W-1:0] LEAF_RB = 8'd34;
  localparam logic [CH_W-1:0] LEAF_G = 8'd139;
  localparam logic [12:0] DIV5_MUL = 13'd6554;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_COLS     = 3'd4,
    REG_ROWS     = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic              func;
    logic [10:0]       pixel_col;
    logic [10:0]       pixel_row;
    logic [7:0]        pixel_red;
    logic [7:0]        pixel_green;
    logic [7:0]        pixel_blue;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [23:0] packed_rgb;
    logic [10:0] proj_col;
    logic [10:0] proj_row;
  } out_item_t;

  typedef struct packed {
    logic        func;
    logic        wr_ok;
    logic [10:0] col;
    logic [10:0] row;
    logic [23:0] rgb;
  } side_t;

  typedef struct packed {
    logic hit;
    logic point;
  } tag_t;

  function automatic logic [CH_W-1:0] div5(input logic [SUM_W-1:0] s);
    logic [23:0] p;
    p = 24'(s) * 24'(DIV5_MUL);
    return p[22:15];
  endfunction

endpackage

>>> rtl/ppc_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready item channel with source and sink views.
// Payload type is set per instance, normally a ppc_pkg item struct.
interface ppc_stream_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/ppc_axis.sv
`timescale 1ns / 1ps
// One projection axis: multiply, sum, range check and a restoring divider,
// one quotient bit per stage. Depends on ppc_pkg.
module ppc_axis #(
  parameter int QW = 11
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ppc_pkg::FIX_W-1:0]   f,
  input  logic [ppc_pkg::FIX_W-1:0]   c,
  input  logic signed [31:0]          p,
  input  logic signed [31:0]          z,
  output logic                        ok,
  output logic [QW-1:0]               q
);
  localparam int NW = ppc_pkg::NUM_W;
  localparam int DW = ppc_pkg::DEN_W;

  logic signed [52:0] pf_a, cz_a;
  logic signed [31:0] z_a;
  logic signed [53:0] num;
  logic [NW-1:0]      n_b;
  logic [DW-1:0]      d_b;
  logic               pos_b;

  logic [NW-1:0] rem [QW];
  logic [DW-1:0] dv  [QW];
  logic          okv [QW+1];
  logic [QW-1:0] qv  [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      pf_a <= $signed({1'b0, f}) * p;
      cz_a <= $signed({1'b0, c}) * z;
      z_a  <= z;
    end
  end

  assign num = 54'(pf_a) + 54'(cz_a);

  always_ff @(posedge clk) begin
    if (en) begin
      pos_b <= (num > 0) && (z_a > 0);
      n_b   <= (NW'(num) << 1) + (NW'(z_a[30:0]) << 8);
      d_b   <= {z_a[30:0], 9'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      okv[0] <= pos_b && (n_b < (NW'(d_b) << QW));
      rem[0] <= n_b;
      dv[0]  <= d_b;
      qv[0]  <= '0;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    localparam int B = QW - 1 - i;
    logic [NW-1:0] sub;
    logic          take;
    assign sub  = NW'(dv[i]) << B;
    assign take = rem[i] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        okv[i+1] <= okv[i];
        qv[i+1]  <= qv[i] | (take ? (QW'(1) << B) : '0);
      end
    end
    if (i < QW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= take ? rem[i] - sub : rem[i];
          dv[i+1]  <= dv[i];
        end
      end
    end
  end

  assign ok = okv[QW];
  assign q  = qv[QW];
endmodule

>>> rtl/ppc_frame_mem.sv
`timescale 1ns / 1ps
// Frame store: five copies, each written with every pixel and read at one tap.
// Depends on ppc_pkg. Read data is registered; en holds everything.
module ppc_frame_mem #(
  parameter int AW = 22,
  parameter int DEPTH = 4194304
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr [ppc_pkg::NTAP],
  output logic [23:0]   rdata [ppc_pkg::NTAP]
);
  for (genvar k = 0; k < ppc_pkg::NTAP; k++) begin : g_copy
    logic [23:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (en) begin
        if (we) begin
          mem[waddr] <= wdata;
        end
        if (re) begin
          rdata[k] <= mem[raddr[k]];
        end
      end
    end
  end
endmodule

>>> rtl/point_projection_colorizer.sv
`timescale 1ns / 1ps
// Top level of the point projection colorizer: APB registers, two axis units,
// bound check, frame store and colour averaging. Uses ppc_pkg, ppc_stream_if,
// ppc_axis and ppc_frame_mem.
//
//   channel  | dir | content
//   points   | in  | pixel write (func 0) or point query (func 1)
//   results  | out | hit, packed_rgb, proj_col, proj_row per query
//   apb      | in  | six configuration registers, 4-byte stride
//
// One item per cycle; QW = clog2 of the larger frame bound (11 at defaults)
// gives the one-bit-per-stage divider its depth. Pixel writes take effect in
// program order.
// rst clears all valid bits and the registers; the store is not cleared.
// A stalled result holds the whole pipeline; nothing is lost or repeated.
module point_projection_colorizer #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppc_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  ppc_stream_if.sink                  points,
  ppc_stream_if.source                results
);
  localparam int QW = $clog2((MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS);
  localparam int LA = 3 + QW;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW = $clog2(DEPTH);
  localparam int FW = ppc_pkg::FIX_W;
  localparam int SW = ppc_pkg::SIZE_W;
  localparam int NT = ppc_pkg::NTAP;
  localparam int CW = ppc_pkg::CH_W;
  localparam int UW = ppc_pkg::SUM_W;

  logic [FW-1:0] focal_x, focal_y, center_x, center_y;
  logic [SW-1:0] image_cols, image_rows;
  ppc_pkg::reg_index_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = ppc_pkg::reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x    <= ppc_pkg::RST_FOCAL_X;
      focal_y    <= ppc_pkg::RST_FOCAL_Y;
      center_x   <= ppc_pkg::RST_CENTER_X;
      center_y   <= ppc_pkg::RST_CENTER_Y;
      image_cols <= ppc_pkg::RST_COLS;
      image_rows <= ppc_pkg::RST_ROWS;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        ppc_pkg::REG_FOCAL_X:  focal_x <= pwdata[FW-1:0];
        ppc_pkg::REG_FOCAL_Y:  focal_y <= pwdata[FW-1:0];
        ppc_pkg::REG_CENTER_X: center_x <= pwdata[FW-1:0];
        ppc_pkg::REG_CENTER_Y: center_y <= pwdata[FW-1:0];
        ppc_pkg::REG_COLS:     image_cols <= pwdata[SW-1:0];
        ppc_pkg::REG_ROWS:     image_rows <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ppc_pkg::REG_FOCAL_X:  prdata = 32'(focal_x);
      ppc_pkg::REG_FOCAL_Y:  prdata = 32'(focal_y);
      ppc_pkg::REG_CENTER_X: prdata = 32'(center_x);
      ppc_pkg::REG_CENTER_Y: prdata = 32'(center_y);
      ppc_pkg::REG_COLS:     prdata = 32'(image_cols);
      ppc_pkg::REG_ROWS:     prdata = 32'(image_rows);
      default:               prdata = '0;
    endcase
  end

  // advance whenever the output register is free or being drained
  logic adv;
  assign adv = !results.valid || results.ready;
  assign points.ready = adv;

  logic           side_v [LA];
  ppc_pkg::side_t side   [LA];
  ppc_pkg::side_t side_in;

  always_comb begin
    side_in.func  = points.data.func;
    side_in.wr_ok = (points.data.func == ppc_pkg::FUNC_PIXEL)
                    && (int'(points.data.pixel_col) < MAX_COLS)
                    && (int'(points.data.pixel_row) < MAX_ROWS);
    side_in.col   = points.data.pixel_col;
    side_in.row   = points.data.pixel_row;
    side_in.rgb   = {points.data.pixel_red, points.data.pixel_green, points.data.pixel_blue};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LA; i++) side_v[i] <= 1'b0;
    end else if (adv) begin
      side_v[0] <= points.valid;
      for (int i = 1; i < LA; i++) side_v[i] <= side_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_in;
      for (int i = 1; i < LA; i++) side[i] <= side[i-1];
    end
  end

  logic          ok_x, ok_y;
  logic [QW-1:0] qx, qy;

  ppc_axis #(.QW(QW)) u_axis_x (
    .clk(clk), .en(adv), .f(focal_x), .c(center_x),
    .p(points.data.point_x), .z(points.data.point_z), .ok(ok_x), .q(qx)
  );

  ppc_axis #(.QW(QW)) u_axis_y (
    .clk(clk), .en(adv), .f(focal_y), .c(center_y),
    .p(points.data.point_y), .z(points.data.point_z), .ok(ok_y), .q(qy)
  );

  // bound check and address generation
  logic [14:0]    cols_e, rows_e;
  logic           hit_c;
  logic [AW-1:0]  ctr_c;
  logic           b_v;
  ppc_pkg::tag_t  b_tag;
  logic [QW-1:0]  b_col, b_row;
  logic           b_we;
  logic [AW-1:0]  b_waddr;
  logic [23:0]    b_wdata;
  logic [AW-1:0]  b_raddr [NT];

  assign cols_e = (15'(image_cols) > 15'(MAX_COLS)) ? 15'(MAX_COLS) : 15'(image_cols);
  assign rows_e = (15'(image_rows) > 15'(MAX_ROWS)) ? 15'(MAX_ROWS) : 15'(image_rows);
  assign hit_c  = ok_x && ok_y && (cols_e >= 15'd3) && (rows_e >= 15'd3)
                  && (15'(qx) >= 15'd1) && (15'(qx) <= cols_e - 15'd2)
                  && (15'(qy) >= 15'd1) && (15'(qy) <= rows_e - 15'd2);
  assign ctr_c  = AW'(qy) * AW'(MAX_COLS) + AW'(qx);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= side_v[LA-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_tag.point <= side[LA-1].func != ppc_pkg::FUNC_PIXEL;
      b_tag.hit   <= hit_c && (side[LA-1].func != ppc_pkg::FUNC_PIXEL);
      b_col       <= qx;
      b_row       <= qy;
      b_we        <= side_v[LA-1] && side[LA-1].wr_ok;
      b_waddr     <= AW'(side[LA-1].row) * AW'(MAX_COLS) + AW'(side[LA-1].col);
      b_wdata     <= side[LA-1].rgb;
      b_raddr[0]  <= ctr_c;
      b_raddr[1]  <= ctr_c + AW'(MAX_COLS);
      b_raddr[2]  <= ctr_c + AW'(1);
      b_raddr[3]  <= ctr_c - AW'(MAX_COLS);
      b_raddr[4]  <= ctr_c - AW'(1);
    end
  end

  logic [23:0] rdata [NT];

  ppc_frame_mem #(.AW(AW), .DEPTH(DEPTH)) u_mem (
    .clk(clk), .en(adv), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_v && b_tag.hit), .raddr(b_raddr), .rdata(rdata)
  );

  logic          m_v;
  ppc_pkg::tag_t m_tag;
  logic [QW-1:0] m_col, m_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tag <= b_tag;
      m_col <= b_col;
      m_row <= b_row;
    end
  end

  // channel sums
  logic [UW-1:0] sr_c, sg_c, sb_c;
  logic          s_v;
  ppc_pkg::tag_t s_tag;
  logic [QW-1:0] s_col, s_row;
  logic [UW-1:0] s_r, s_g, s_b;

  always_comb begin
    sr_c = '0;
    sg_c = '0;
    sb_c = '0;
    for (int k = 0; k < NT; k++) begin
      sr_c = sr_c + UW'(rdata[k][23:16]);
      sg_c = sg_c + UW'(rdata[k][15:8]);
      sb_c = sb_c + UW'(rdata[k][7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else if (adv) begin
      s_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_tag <= m_tag;
      s_col <= m_col;
      s_row <= m_row;
      s_r   <= sr_c;
      s_g   <= sg_c;
      s_b   <= sb_c;
    end
  end

  // average, leaf recolor, pack
  logic [CW-1:0]      r5, g5, b5;
  logic               leaf;
  ppc_pkg::out_item_t res_c;

  assign r5   = ppc_pkg::div5(s_r);
  assign g5   = ppc_pkg::div5(s_g);
  assign b5   = ppc_pkg::div5(s_b);
  assign leaf = (g5 > r5) && (g5 > b5);

  always_comb begin
    res_c = '0;
    if (s_tag.hit) begin
      res_c.hit        = 1'b1;
      res_c.packed_rgb = leaf ? {ppc_pkg::LEAF_RB, ppc_pkg::LEAF_G, ppc_pkg::LEAF_RB}
                              : {r5, g5, b5};
      res_c.proj_col   = 11'(s_col);
      res_c.proj_row   = 11'(s_row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (adv) begin
      results.valid <= s_v && s_tag.point;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      results.data <= res_c;
    end
  end

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.data.hit |->
      results.data.packed_rgb == '0 && results.data.proj_col == '0
      && results.data.proj_row == '0)
    else $error("miss result carries nonzero payload");

  a_hit_inside: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.hit |->
      results.data.proj_col != '0 && results.data.proj_row != '0)
    else $error("hit on frame edge");

  a_read_point: assert property (@(posedge clk) disable iff (rst)
    b_v && b_tag.hit |-> !b_we)
    else $error("store read and write from one item");
`endif
endmodule
